FILE: sv/wast_pkg.sv
`timescale 1ns / 1ps
package wast_pkg;

    // table geometry
    localparam int MAX_ENTRIES_DEF = 8;
    localparam int NUM_ALLOWED     = 4;
    localparam int ADDR_W          = 64;
    localparam int CMD_W           = 2;
    localparam int CFG_IDX_W       = 2;

    // command codes (code 3 acts as a query)
    localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_NOT_ALLOWED = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND   = 2'd2;
    localparam logic [1:0] ST_FULL        = 2'd3;

    // identity index when no allowed register matches
    localparam logic [2:0] NO_IDENTITY = 3'd4;

    // allowed-address register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ALLOWED_0 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ALLOWED_1 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ALLOWED_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ALLOWED_3 = 2'd3;

    // allowed-address reset values
    localparam logic [ADDR_W-1:0] ALLOWED_RESET [NUM_ALLOWED] = '{
        64'h0013_A200_407A_866B,
        64'h0013_A200_407A_8640,
        64'h0013_A200_407A_8676,
        64'h0013_A200_40AE_5BE4
    };

    // sequencer states
    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_IDENT = 5'b00010,
        S_SRCH  = 5'b00100,
        S_SHIFT = 5'b01000,
        S_FIN   = 5'b10000
    } state_t;

endpackage

FILE: sv/wast_if.sv
`timescale 1ns / 1ps

// request channel: command and address
interface wast_req_if
    import wast_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [ADDR_W-1:0] address;

    modport source (output valid, output cmd, output address, input ready);
    modport sink   (input valid, input cmd, input address, output ready);
endinterface

// response channel: one result per request
interface wast_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic       present;
    logic [2:0] identity_index;
    logic [3:0] entry_count;

    modport source (output valid, output status, output present,
                    output identity_index, output entry_count, input ready);
    modport sink   (input valid, input status, input present,
                    input identity_index, input entry_count, output ready);
endinterface

FILE: sv/wast_ram.sv
`timescale 1ns / 1ps
module wast_ram
    import wast_pkg::*;
#(
    parameter int DEPTH = MAX_ENTRIES_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  logic [ADDR_W-1:0] wdata,
    input  logic [AW-1:0]     raddr,
    output logic [ADDR_W-1:0] rdata
);

    logic [ADDR_W-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

FILE: sv/whitelisted_address_set_table.sv
`timescale 1ns / 1ps
// whitelisted address set table
// keeps a packed set of up to MAX_ENTRIES 64-bit addresses in a small ram.
// req channel (valid/ready): cmd (add, remove, query) and address.
// rsp channel (valid/ready): status, present, identity_index, entry_count.
// cfg port: cfg_we, cfg_index, cfg_data write the four allowed-address
// registers; write only while no request is in flight.
// one request at a time: a single 64-bit comparator is shared by the
// allowed-register check and the entry scan (the ram read pipelined one
// ahead), followed by a finish state.
// a remove that finds its entry before the last slot runs a shift pass
// that moves every later entry down one slot before the finish state.
// req.ready and rsp valid rise together when the finish state is left,
// so the next request can be accepted while the result is still waiting.
// req.ready is high only while the sequencer is idle; a finished result
// sits in the output register, and a stalled receiver holds the next
// result in the finish state until the register frees.
// reset clears the count, the output valid bit and the sequencer and
// loads the allowed registers with their defaults; ram content is not
// cleared and only slots below count are ever compared or moved.
module whitelisted_address_set_table
    import wast_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    wast_req_if.sink             req,
    wast_rsp_if.source           rsp,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ADDR_W-1:0]    cfg_data
);

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ENTRIES);

    state_t            state_reg, state_next;
    logic [ADDR_W-1:0] allowed_reg [NUM_ALLOWED];
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CMD_W-1:0]  cmd_reg, cmd_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [1:0]        id_cnt_reg, id_cnt_next;
    logic [2:0]        ident_reg, ident_next;
    logic [IDX_W-1:0]  k_reg, k_next;
    logic              found_reg, found_next;

    logic              out_valid_reg, out_valid_next;
    logic [1:0]        out_status_reg, out_status_next;
    logic              out_present_reg, out_present_next;
    logic [2:0]        out_ident_reg, out_ident_next;
    logic [3:0]        out_count_reg, out_count_next;

    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [ADDR_W-1:0] ram_wdata;
    logic [IDX_W-1:0]  ram_raddr;
    logic [ADDR_W-1:0] ram_rdata;

    logic [ADDR_W-1:0] cmp_b;
    logic              cmp_eq;
    logic [CNT_W-1:0]  k_ext, k_inc, k_inc2;
    logic [CNT_W+3:0]  count_wide;
    logic              req_fire, fin_go;

    // entry storage
    wast_ram #(
        .DEPTH (MAX_ENTRIES),
        .AW    (IDX_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // allowed-address registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_ALLOWED; i++)
            begin
                allowed_reg[i] <= ALLOWED_RESET[i];
            end
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ALLOWED_0: allowed_reg[0] <= cfg_data;
                REG_ALLOWED_1: allowed_reg[1] <= cfg_data;
                REG_ALLOWED_2: allowed_reg[2] <= cfg_data;
                REG_ALLOWED_3: allowed_reg[3] <= cfg_data;
                default:       allowed_reg[0] <= allowed_reg[0];
            endcase
        end
    end

    // shared comparator: allowed register during ident, ram data otherwise
    assign cmp_b  = (state_reg == S_IDENT) ? allowed_reg[id_cnt_reg] : ram_rdata;
    assign cmp_eq = (addr_reg == cmp_b);

    assign k_ext  = CNT_W'(k_reg);
    assign k_inc  = k_ext + CNT_W'(1);
    assign k_inc2 = k_ext + CNT_W'(2);

    assign req_fire  = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign fin_go    = (state_reg == S_FIN) && (!out_valid_reg || rsp.ready);

    // sequencer
    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        cmd_next         = cmd_reg;
        addr_next        = addr_reg;
        id_cnt_next      = id_cnt_reg;
        ident_next       = ident_reg;
        k_next           = k_reg;
        found_next       = found_reg;
        out_valid_next   = out_valid_reg && !rsp.ready;
        out_status_next  = out_status_reg;
        out_present_next = out_present_reg;
        out_ident_next   = out_ident_reg;
        out_count_next   = out_count_reg;
        ram_we           = 1'b0;
        ram_waddr        = k_reg;
        ram_wdata        = ram_rdata;
        ram_raddr        = '0;
        count_wide       = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    cmd_next    = req.cmd;
                    addr_next   = req.address;
                    id_cnt_next = '0;
                    ident_next  = NO_IDENTITY;
                    found_next  = 1'b0;
                    k_next      = '0;
                    state_next  = S_IDENT;
                end
            end

            // one allowed register per cycle, lowest index wins
            S_IDENT:
            begin
                if (cmp_eq && (ident_reg == NO_IDENTITY))
                begin
                    ident_next = {1'b0, id_cnt_reg};
                end
                id_cnt_next = id_cnt_reg + 2'd1;
                if (id_cnt_reg == 2'(NUM_ALLOWED - 1))
                begin
                    state_next = (count_reg == '0) ? S_FIN : S_SRCH;
                end
            end

            // scan slot k, next slot read already issued
            S_SRCH:
            begin
                ram_raddr = (k_inc < CNT_MAX) ? k_inc[IDX_W-1:0] : '0;
                if (cmp_eq)
                begin
                    found_next = 1'b1;
                    if ((cmd_reg == CMD_REMOVE) && (k_inc != count_reg))
                    begin
                        state_next = S_SHIFT;
                    end
                    else
                    begin
                        state_next = S_FIN;
                    end
                end
                else if (k_inc == count_reg)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    k_next = k_inc[IDX_W-1:0];
                end
            end

            // move slot k+1 down to slot k
            S_SHIFT:
            begin
                ram_raddr = (k_inc2 < CNT_MAX) ? k_inc2[IDX_W-1:0] : '0;
                ram_we    = 1'b1;
                ram_waddr = k_reg;
                ram_wdata = ram_rdata;
                if (k_inc2 == count_reg)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    k_next = k_inc[IDX_W-1:0];
                end
            end

            // settle the result and update the table
            S_FIN:
            begin
                if (fin_go)
                begin
                    out_ident_next = ident_reg;
                    if (cmd_reg == CMD_ADD)
                    begin
                        if (ident_reg == NO_IDENTITY)
                        begin
                            out_status_next  = ST_NOT_ALLOWED;
                            out_present_next = found_reg;
                        end
                        else if (found_reg)
                        begin
                            out_status_next  = ST_OK;
                            out_present_next = 1'b1;
                        end
                        else if (count_reg >= CNT_MAX)
                        begin
                            out_status_next  = ST_FULL;
                            out_present_next = 1'b0;
                        end
                        else
                        begin
                            ram_we           = 1'b1;
                            ram_waddr        = count_reg[IDX_W-1:0];
                            ram_wdata        = addr_reg;
                            count_next       = count_reg + CNT_W'(1);
                            out_status_next  = ST_OK;
                            out_present_next = 1'b1;
                        end
                    end
                    else if (cmd_reg == CMD_REMOVE)
                    begin
                        // entries are unique, so a removed address is gone
                        out_present_next = 1'b0;
                        if (found_reg)
                        begin
                            count_next      = count_reg - CNT_W'(1);
                            out_status_next = ST_OK;
                        end
                        else
                        begin
                            out_status_next = ST_NOT_FOUND;
                        end
                    end
                    else
                    begin
                        out_status_next  = found_reg ? ST_OK : ST_NOT_FOUND;
                        out_present_next = found_reg;
                    end
                    count_wide     = {4'b0, count_next};
                    out_count_next = count_wide[3:0];
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // working and result payload
    always_ff @(posedge clk)
    begin
        cmd_reg         <= cmd_next;
        addr_reg        <= addr_next;
        id_cnt_reg      <= id_cnt_next;
        ident_reg       <= ident_next;
        k_reg           <= k_next;
        found_reg       <= found_next;
        out_status_reg  <= out_status_next;
        out_present_reg <= out_present_next;
        out_ident_reg   <= out_ident_next;
        out_count_reg   <= out_count_next;
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = out_status_reg;
    assign rsp.present        = out_present_reg;
    assign rsp.identity_index = out_ident_reg;
    assign rsp.entry_count    = out_count_reg;

`ifndef NO_ASSERTIONS
    // the table never holds more than its capacity
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_MAX)
        else $error("entry count above capacity");

    // an accepted request starts the allowed-register check
    a_accept_ident: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> (state_reg == S_IDENT))
        else $error("request not followed by ident check");

    // the shift pass only runs for a remove that found its entry
    a_shift_remove: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT) |-> ((cmd_reg == CMD_REMOVE) && found_reg))
        else $error("shift pass without a matching remove");

    // a full status is only reported on a full table
    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (fin_go && (out_status_next == ST_FULL)) |=> (count_reg == CNT_MAX))
        else $error("table full reported below capacity");
`endif

endmodule

FILE: tb/tb_whitelisted_address_set_table.sv
`timescale 1ns / 1ps
module tb_whitelisted_address_set_table;
    import wast_pkg::*;

    // unused command code, handled by the block as a query
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_REQUESTS = 70;

    localparam logic [CFG_IDX_W-1:0] ALLOWED_REGS [NUM_ALLOWED] = '{
        REG_ALLOWED_0, REG_ALLOWED_1, REG_ALLOWED_2, REG_ALLOWED_3
    };

    typedef struct packed {
        logic [CMD_W-1:0]  op;
        logic [ADDR_W-1:0] addr;
    } table_request_t;

    typedef struct packed {
        logic [1:0] status;
        logic       present;
        logic [2:0] identity_index;
        logic [3:0] entry_count;
    } table_result_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [ADDR_W-1:0] cfg_data;

    wast_req_if req_bus ();
    wast_rsp_if rsp_bus ();

    whitelisted_address_set_table DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_bus),
        .rsp       (rsp_bus),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // shadow copy of the table and the allowed registers
    logic [ADDR_W-1:0] allowed_shadow [NUM_ALLOWED];
    logic [ADDR_W-1:0] stored_shadow [MAX_ENTRIES_DEF];
    int stored_count;

    table_request_t pending_requests [$];
    table_result_t expected_results [$];
    table_request_t next_req;
    table_result_t got_result;
    table_result_t want_result;

    int req_gap;
    int rsp_stall;
    bit quiet_mode;
    int requests_accepted;
    int mismatch_count;
    int settings_count;
    int status_seen [4];

    // gap length: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        if (quiet_mode)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        else if (r < 93)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // lowest allowed register equal to the address
    function automatic logic [2:0] identity_lookup(logic [ADDR_W-1:0] a);
        for (int k = 0; k < NUM_ALLOWED; k++)
        begin
            if (allowed_shadow[k] == a)
                return 3'(k);
        end
        return NO_IDENTITY;
    endfunction

    // slot holding the address, stored_count when absent
    function automatic int slot_lookup(logic [ADDR_W-1:0] a);
        for (int k = 0; k < stored_count; k++)
        begin
            if (stored_shadow[k] == a)
                return k;
        end
        return stored_count;
    endfunction

    // apply one request to the shadow table and give the result it causes
    function automatic table_result_t apply_table_request(logic [CMD_W-1:0] op,
                                                          logic [ADDR_W-1:0] a);
        table_result_t res;
        logic [2:0] ident;
        int slot;
        ident = identity_lookup(a);
        slot = slot_lookup(a);
        if (op == CMD_ADD)
        begin
            if (ident == NO_IDENTITY)
            begin
                res.status = ST_NOT_ALLOWED;
                res.present = (slot < stored_count);
            end
            else if (slot < stored_count)
            begin
                res.status = ST_OK;
                res.present = 1'b1;
            end
            else if (stored_count >= MAX_ENTRIES_DEF)
            begin
                res.status = ST_FULL;
                res.present = 1'b0;
            end
            else
            begin
                stored_shadow[stored_count] = a;
                stored_count++;
                res.status = ST_OK;
                res.present = 1'b1;
            end
        end
        else if (op == CMD_REMOVE)
        begin
            if (slot < stored_count)
            begin
                for (int k = slot + 1; k < stored_count; k++)
                    stored_shadow[k - 1] = stored_shadow[k];
                stored_count--;
                res.status = ST_OK;
                res.present = (slot_lookup(a) < stored_count);
            end
            else
            begin
                res.status = ST_NOT_FOUND;
                res.present = 1'b0;
            end
        end
        else
        begin
            res.status = (slot < stored_count) ? ST_OK : ST_NOT_FOUND;
            res.present = (slot < stored_count);
        end
        res.identity_index = ident;
        res.entry_count = 4'(stored_count);
        return res;
    endfunction

    task automatic push_request(input logic [CMD_W-1:0] op, input logic [ADDR_W-1:0] a);
        table_request_t item;
        item.op = op;
        item.addr = a;
        pending_requests.push_back(item);
    endtask

    // wait until every request is accepted and every result has come back
    task automatic wait_drained();
        while (pending_requests.size() != 0 || req_bus.valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // write all four allowed registers back to back while idle
    task automatic write_allowed_set(input logic [ADDR_W-1:0] vals [NUM_ALLOWED]);
        for (int k = 0; k < NUM_ALLOWED; k++)
        begin
            @(posedge clk);
            cfg_we <= 1'b1;
            cfg_index <= ALLOWED_REGS[k];
            cfg_data <= vals[k];
            allowed_shadow[ALLOWED_REGS[k]] = vals[k];
        end
        @(posedge clk);
        cfg_we <= 1'b0;
        settings_count++;
    endtask

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_bus.valid <= 1'b0;
            req_bus.cmd <= CMD_ADD;
            req_bus.address <= '0;
            req_gap <= 0;
        end
        else
        begin
            if (req_bus.valid && req_bus.ready)
            begin
                expected_results.push_back(apply_table_request(req_bus.cmd,
                                                               req_bus.address));
                requests_accepted++;
            end
            if (!req_bus.valid || req_bus.ready)
            begin
                if (req_gap > 0)
                begin
                    req_gap <= req_gap - 1;
                    req_bus.valid <= 1'b0;
                end
                else if (pending_requests.size() > 0)
                begin
                    next_req = pending_requests.pop_front();
                    req_bus.valid <= 1'b1;
                    req_bus.cmd <= next_req.op;
                    req_bus.address <= next_req.addr;
                    req_gap <= pick_gap();
                end
                else
                begin
                    req_bus.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_bus.ready <= 1'b0;
            rsp_stall <= 0;
        end
        else
        begin
            if (rsp_bus.valid && rsp_bus.ready)
            begin
                got_result.status = rsp_bus.status;
                got_result.present = rsp_bus.present;
                got_result.identity_index = rsp_bus.identity_index;
                got_result.entry_count = rsp_bus.entry_count;
                if (expected_results.size() == 0)
                begin
                    $error("result with no request outstanding: status %0d",
                           got_result.status);
                    mismatch_count++;
                end
                else
                begin
                    want_result = expected_results.pop_front();
                    status_seen[want_result.status]++;
                    if (got_result.status !== want_result.status)
                    begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want_result.status, got_result.status);
                        mismatch_count++;
                    end
                    if (got_result.present !== want_result.present)
                    begin
                        $error("present mismatch: expected %0d, actual %0d",
                               want_result.present, got_result.present);
                        mismatch_count++;
                    end
                    if (got_result.identity_index !== want_result.identity_index)
                    begin
                        $error("identity_index mismatch: expected %0d, actual %0d",
                               want_result.identity_index, got_result.identity_index);
                        mismatch_count++;
                    end
                    if (got_result.entry_count !== want_result.entry_count)
                    begin
                        $error("entry_count mismatch: expected %0d, actual %0d",
                               want_result.entry_count, got_result.entry_count);
                        mismatch_count++;
                    end
                end
            end
            if (rsp_stall > 0)
            begin
                rsp_stall <= rsp_stall - 1;
                rsp_bus.ready <= 1'b0;
            end
            else if (!quiet_mode && $urandom_range(0, 99) < 20)
            begin
                rsp_stall <= pick_gap();
                rsp_bus.ready <= 1'b0;
            end
            else
            begin
                rsp_bus.ready <= 1'b1;
            end
        end
    end

    // stimulus sequence
    initial
    begin
        logic [ADDR_W-1:0] candidates [16];
        logic [ADDR_W-1:0] new_allowed [NUM_ALLOWED];
        logic [ADDR_W-1:0] addr_pick;
        logic [CMD_W-1:0] op_pick;
        int r;

        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_ALLOWED_0;
        cfg_data = '0;
        quiet_mode = 1'b0;
        settings_count = 0;
        for (int k = 0; k < NUM_ALLOWED; k++)
            allowed_shadow[k] = ALLOWED_RESET[k];
        // pool of addresses that the allowed registers rotate through
        for (int k = 0; k < 16; k++)
            candidates[k] = 64'h0013_A200_4100_0000 + 64'(k * 37 + 5);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table, default allowed set
        push_request(CMD_QUERY, ALLOWED_RESET[0]);
        push_request(CMD_REMOVE, ALLOWED_RESET[1]);
        push_request(CMD_ADD, 64'h0);
        push_request(CMD_ADD, '1);
        for (int k = 0; k < NUM_ALLOWED; k++)
            push_request(CMD_ADD, ALLOWED_RESET[k]);
        push_request(CMD_ADD, ALLOWED_RESET[0]);
        push_request(CMD_QUERY, ALLOWED_RESET[2]);
        push_request(CMD_UNUSED, ALLOWED_RESET[3]);
        // remove from the middle shifts the tail down
        push_request(CMD_REMOVE, ALLOWED_RESET[1]);
        push_request(CMD_REMOVE, ALLOWED_RESET[1]);
        push_request(CMD_ADD, ALLOWED_RESET[1]);
        wait_drained();

        // extreme values and two equal registers
        new_allowed = '{64'h0, '1, 64'h0, candidates[0]};
        write_allowed_set(new_allowed);
        push_request(CMD_ADD, 64'h0);
        push_request(CMD_ADD, '1);
        push_request(CMD_ADD, candidates[0]);
        // stored but no longer allowed
        push_request(CMD_ADD, ALLOWED_RESET[0]);
        push_request(CMD_REMOVE, ALLOWED_RESET[0]);
        push_request(CMD_ADD, ALLOWED_RESET[0]);
        wait_drained();

        // fill the table, then one more add, a query and a remove
        new_allowed = '{candidates[1], candidates[2], candidates[3], candidates[4]};
        write_allowed_set(new_allowed);
        push_request(CMD_ADD, candidates[1]);
        push_request(CMD_ADD, candidates[2]);
        push_request(CMD_ADD, candidates[3]);
        push_request(CMD_QUERY, candidates[1]);
        push_request(CMD_REMOVE, '1);
        wait_drained();

        // random phases, each under a new allowed set
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            quiet_mode = (phase % 4 == 3);
            for (int k = 0; k < NUM_ALLOWED; k++)
            begin
                r = $urandom_range(0, 99);
                if (r < 70)
                    new_allowed[k] = candidates[$urandom_range(0, 15)];
                else if (r < 78)
                    new_allowed[k] = 64'h0;
                else if (r < 86)
                    new_allowed[k] = '1;
                else if (r < 94 && k > 0)
                    new_allowed[k] = new_allowed[k - 1];
                else
                    new_allowed[k] = {$urandom, $urandom};
            end
            write_allowed_set(new_allowed);
            for (int n = 0; n < PHASE_REQUESTS; n++)
            begin
                r = $urandom_range(0, 99);
                if (r < 50)
                    op_pick = CMD_ADD;
                else if (r < 72)
                    op_pick = CMD_REMOVE;
                else if (r < 92)
                    op_pick = CMD_QUERY;
                else
                    op_pick = CMD_UNUSED;
                r = $urandom_range(0, 99);
                if (r < 40)
                    addr_pick = allowed_shadow[$urandom_range(0, NUM_ALLOWED - 1)];
                else if (r < 70)
                    addr_pick = candidates[$urandom_range(0, 15)];
                else if (r < 80 && stored_count > 0)
                    addr_pick = stored_shadow[$urandom_range(0, stored_count - 1)];
                else if (r < 92)
                    addr_pick = {$urandom, $urandom};
                else if (r < 95)
                    addr_pick = 64'h0;
                else if (r < 98)
                    addr_pick = '1;
                else
                    addr_pick = 64'h1 << $urandom_range(0, ADDR_W - 1);
                push_request(op_pick, addr_pick);
                // stored_count is only read as a hint; the shadow moves at acceptance
            end
            wait_drained();
        end
        quiet_mode = 1'b0;

        // let any late result show up
        repeat (30) @(posedge clk);
        $display("covered %0d requests under %0d allowed-register settings",
                 requests_accepted, settings_count);
        $display("outcomes: ok %0d, not allowed %0d, not found %0d, table full %0d",
                 status_seen[ST_OK], status_seen[ST_NOT_ALLOWED],
                 status_seen[ST_NOT_FOUND], status_seen[ST_FULL]);
        if (mismatch_count == 0 && expected_results.size() == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // overall time limit
    initial
    begin
        #20_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
